// ===== rtl/core/ftia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftia_pkg
// Types and constants shared by the flow table core and its slot cells.
// ----------------------------------------------------------------------------
package ftia_pkg;

    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 8;
    localparam int KIND_W  = 2;

    // Result kinds.
    localparam logic [KIND_W-1:0] EV_NEW   = 2'd0;
    localparam logic [KIND_W-1:0] EV_ENDED = 2'd1;
    localparam logic [KIND_W-1:0] EV_FULL  = 2'd2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_SWEEP_INTERVAL = 8'd0;
    localparam logic [IDX_W-1:0] REG_IDLE_TIMEOUT   = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] SWEEP_INTERVAL_RST = 8'd5;
    localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST   = 8'd7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic               look_en;
        logic               emit_en;
        logic               sweep_due;
        logic               hit_any;
        logic [CFG_W-1:0]   timeout;
        logic [ADDR_W-1:0]  key_src;
        logic [ADDR_W-1:0]  key_dst;
        logic [TIME_W-1:0]  now;
    } t_cell_ctl;

    // Passed from each cell to its higher neighbor.
    typedef struct packed {
        logic               free_seen;
        logic               hit_seen;
        logic               exp_seen;
        logic               pend_seen;
        logic               pend_more;
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dst;
        logic [COUNT_W-1:0] cnt;
    } t_link;

endpackage

// ===== rtl/core/ftia_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftia_cell
// One slot of the flow table: holds a flow, matches the broadcast key and
// takes part in the free-slot and report priority chains.
// ----------------------------------------------------------------------------
module ftia_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ftia_pkg::t_cell_ctl i_ctl,
    input  ftia_pkg::t_link   i_link,
    output ftia_pkg::t_link   o_link
);
    import ftia_pkg::*;

    logic               r_valid;
    logic               r_pend;
    logic [ADDR_W-1:0]  r_src;
    logic [ADDR_W-1:0]  r_dst;
    logic [TIME_W-1:0]  r_last;
    logic [COUNT_W-1:0] r_cnt;

    logic               hit;
    logic               install;
    logic               expired;
    logic               grant;
    logic [TIME_W-1:0]  idle;

    assign hit     = r_valid && (r_src == i_ctl.key_src) && (r_dst == i_ctl.key_dst);
    assign install = i_ctl.look_en && !i_ctl.hit_any && !r_valid && !i_link.free_seen;
    assign idle    = i_ctl.now - r_last;
    // The flow touched by this packet is never aged out by that packet's sweep.
    assign expired = i_ctl.sweep_due && r_valid && !hit &&
                     (idle > {{(TIME_W-CFG_W){1'b0}}, i_ctl.timeout});
    assign grant   = i_ctl.emit_en && r_pend && !i_link.pend_seen;

    always_comb begin
        o_link           = i_link;
        o_link.free_seen = i_link.free_seen | !r_valid;
        o_link.hit_seen  = i_link.hit_seen | hit;
        o_link.exp_seen  = i_link.exp_seen | expired;
        o_link.pend_seen = i_link.pend_seen | r_pend;
        o_link.pend_more = i_link.pend_more | (r_pend & i_link.pend_seen);
        o_link.src       = i_link.src | (grant ? r_src : '0);
        o_link.dst       = i_link.dst | (grant ? r_dst : '0);
        o_link.cnt       = i_link.cnt | (grant ? r_cnt : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (i_ctl.look_en) begin
            r_pend <= expired;
            if (install) begin
                r_valid <= 1'b1;
            end
        end else if (grant) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.look_en && hit) begin
            r_last <= i_ctl.now;
            if (r_cnt != COUNT_MAX) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (install) begin
            r_src  <= i_ctl.key_src;
            r_dst  <= i_ctl.key_dst;
            r_last <= i_ctl.now;
            r_cnt  <= {{(COUNT_W-1){1'b0}}, 1'b1};
        end
    end

endmodule

// ===== rtl/core/flow_table_with_idle_aging_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_table_with_idle_aging_core
// Flow cache keyed by address pair, with periodic removal of idle flows.
// ----------------------------------------------------------------------------
// Usage:
//   Packet headers enter on the input channel (valid/ready). Results leave on
//   the output channel, one event per beat; o_last_of_run marks the final
//   beat caused by a header. A header that refreshes a known flow and
//   triggers no removals produces no beat at all.
//   Configuration writes (sweep interval, idle timeout) use their own channel
//   and are always taken; write them only while the block is idle.
// Timing:
//   A header is taken in the idle state and looked up in all slots at once in
//   the lookup state. Each flow removed by an idle sweep is then reported
//   from the emit state; the report chain hands out one flow per cycle
//   through the output register while that register is not stalled.
// Reset:
//   All slots become free, the sweep mark is re-armed by the next header and
//   the configuration returns to interval 5, timeout 7.
// Stall:
//   While the output register holds an untaken beat, lookup and reporting
//   wait; the input is not taken until the current header is finished.
// ----------------------------------------------------------------------------
module flow_table_with_idle_aging_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ftia_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [ftia_pkg::CFG_W-1:0]    i_cfg_data,
    // packet headers
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ftia_pkg::ADDR_W-1:0]   i_src_addr,
    input  logic [ftia_pkg::ADDR_W-1:0]   i_dst_addr,
    input  logic [ftia_pkg::TIME_W-1:0]   i_now_seconds,
    // events
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ftia_pkg::KIND_W-1:0]   o_event_kind,
    output logic [ftia_pkg::ADDR_W-1:0]   o_flow_src,
    output logic [ftia_pkg::ADDR_W-1:0]   o_flow_dst,
    output logic [ftia_pkg::COUNT_W-1:0]  o_packet_count,
    output logic                          o_last_of_run
);
    import ftia_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CFG_W-1:0]   r_interval;
    logic [CFG_W-1:0]   r_timeout;
    logic               r_started;
    logic [TIME_W-1:0]  r_mark;
    logic [ADDR_W-1:0]  r_src;
    logic [ADDR_W-1:0]  r_dst;
    logic [TIME_W-1:0]  r_now;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [ADDR_W-1:0]  r_osrc;
    logic [ADDR_W-1:0]  r_odst;
    logic [COUNT_W-1:0] r_ocnt;
    logic               r_olast;

    t_cell_ctl          ctl;
    t_link              link [TABLE_DEPTH+1];
    t_link              tail;

    logic               in_beat;
    logic               can_load;
    logic               look_en;
    logic               emit_en;
    logic               look_load;
    logic               sweep_due;
    logic [TIME_W-1:0]  since_mark;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_beat     = i_in_valid && o_in_ready;

    assign can_load  = !r_out_valid || i_out_ready;
    assign look_en   = (r_state == ST_LOOK) && can_load;
    assign emit_en   = (r_state == ST_EMIT) && can_load;
    assign since_mark = r_now - r_mark;
    assign sweep_due = since_mark >= {{(TIME_W-CFG_W){1'b0}}, r_interval};

    assign tail      = link[TABLE_DEPTH];
    assign look_load = look_en && !tail.hit_seen;

    always_comb begin
        ctl.look_en   = look_en;
        ctl.emit_en   = emit_en;
        ctl.sweep_due = sweep_due;
        ctl.hit_any   = tail.hit_seen;
        ctl.timeout   = r_timeout;
        ctl.key_src   = r_src;
        ctl.key_dst   = r_dst;
        ctl.now       = r_now;
    end

    assign link[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ftia_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ctl),
            .i_link (link[g]),
            .o_link (link[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (look_en) begin
                    n_state = tail.exp_seen ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit_en && !tail.pend_more) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_interval  <= SWEEP_INTERVAL_RST;
            r_timeout   <= IDLE_TIMEOUT_RST;
            r_started   <= 1'b0;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_SWEEP_INTERVAL) begin
                    r_interval <= i_cfg_data;
                end else if (i_cfg_index == REG_IDLE_TIMEOUT) begin
                    r_timeout <= i_cfg_data;
                end
            end
            // The first header arms the sweep mark before its own sweep test.
            if (in_beat && !r_started) begin
                r_started <= 1'b1;
                r_mark    <= i_now_seconds;
            end else if (look_en && sweep_due) begin
                r_mark <= r_now;
            end
            if (can_load) begin
                r_out_valid <= look_load || emit_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_src <= i_src_addr;
            r_dst <= i_dst_addr;
            r_now <= i_now_seconds;
        end
        if (look_load) begin
            r_kind  <= tail.free_seen ? EV_NEW : EV_FULL;
            r_osrc  <= r_src;
            r_odst  <= r_dst;
            r_ocnt  <= {{(COUNT_W-1){1'b0}}, tail.free_seen};
            r_olast <= !tail.exp_seen;
        end else if (emit_en) begin
            r_kind  <= EV_ENDED;
            r_osrc  <= tail.src;
            r_odst  <= tail.dst;
            r_ocnt  <= tail.cnt;
            r_olast <= !tail.pend_more;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_kind;
    assign o_flow_src     = r_osrc;
    assign o_flow_dst     = r_odst;
    assign o_packet_count = r_ocnt;
    assign o_last_of_run  = r_olast;

endmodule
